/* rtl/sauv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sauv_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_Q_BND,
      ST_Q_RD,
      ST_Q_AREA,
      ST_Q_AQ,
      ST_Q_SS,
      ST_Q_VN,
      ST_Q_D1,
      ST_Q_D2S,
      ST_Q_D2,
      ST_Q_D3S,
      ST_Q_D3,
      ST_Q_SQS,
      ST_Q_SQ,
      ST_Q_KU,
      ST_Q_N,
      ST_Q_MUL
   } state_type;

   localparam logic       FUNC_LOAD  = 1'b0;
   localparam logic       FUNC_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_RANGE      = 2'd1;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd2;

   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_WINDOW_SIZE  = 3'd2;
   localparam logic [2:0] CSR_K_GAIN       = 3'd3;
   localparam logic [2:0] CSR_DELTA_OFFSET = 3'd4;

   localparam int SUM_W = 24;
   localparam int SQ_W  = 32;

endpackage

`default_nettype wire

/* rtl/sauvola_local_threshold.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                  Handshake
// request  req_func req_pixel req_col req_row     start & !busy
// response rsp_status rsp_is_white rsp_local_*   rsp_strobe, one cycle
// csr      csr_index csr_wdata                    csr_we
//
// Load word: above-row read, then write-back.
// Query word outside the image or before load completes: answered the next cycle.
// Query word in range: 8 table reads, three 64-step restoring divisions and a 32-step root
// on one shared divide/root datapath, then up to 24 steps of serial multiply.
// Synchronous active-high reset; tables are not cleared. Responses cannot be stalled.

module sauvola_local_threshold #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_pixel,
   input  wire logic [7:0]  req_col,
   input  wire logic [7:0]  req_row,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_is_white,
   output logic [15:0]      rsp_local_mean,
   output logic [14:0]      rsp_local_deviation,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int MW    = (DW > HW) ? DW : HW;
   localparam int EW    = (MW > 9) ? MW : 9;
   localparam int RSW   = $clog2(MAX_WIDTH * 255 + 1);
   localparam int RQW   = $clog2(MAX_WIDTH * 65025 + 1);
   localparam int SW    = sauv_pkg::SUM_W;
   localparam int QW    = sauv_pkg::SQ_W;

   sauv_pkg::state_type state_ff, state_in;

   logic [8:0]     width_ff, width_in, height_ff, height_in, window_ff, window_in;
   logic [9:0]     k_ff, k_in;
   logic [7:0]     delta_ff, delta_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [RSW-1:0] rs_ff, rs_in;
   logic [RQW-1:0] rq_ff, rq_in;
   logic           loaded_ff, loaded_in;

   logic [7:0]     qrow_ff, qrow_in, qcol_ff, qcol_in;
   logic [EW-1:0]  y0_ff, y0_in, y1_ff, y1_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic           rd_act_ff, rd_act_in, rd_zf_ff, rd_zf_in;
   logic [2:0]     rd_idx_ff, rd_idx_in;
   logic [31:0]    s_ff, s_in, q_ff, q_in;
   logic [7:0]     p_ff, p_in;
   logic [17:0]    area_ff, area_in;
   logic [63:0]    aq_ff, aq_in, ss_ff, ss_in, vnum_ff, vnum_in;
   logic [35:0]    a2_ff, a2_in;
   logic [63:0]    dvd_ff, dvd_in, dvs_ff, dvs_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [47:0]    mq_ff, mq_in, mpl_ff, mpl_in;
   logic [31:0]    quo1_ff, quo1_in, dq_ff, dq_in;
   logic [42:0]    ku_ff, ku_in;
   logic [95:0]    acc_ff, acc_in, mcand_ff, mcand_in;

   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_white_ff, rsp_white_in;
   logic [15:0]    rsp_mean_ff, rsp_mean_in;
   logic [14:0]    rsp_dev_ff, rsp_dev_in;

   logic [SW-1:0]  sum_mem [DEPTH];
   logic [QW-1:0]  sq_mem [DEPTH];
   logic [SW-1:0]  rd_sum_ff;
   logic [QW-1:0]  rd_sq_ff;
   logic           mem_we;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [SW-1:0]  sum_wd;
   logic [QW-1:0]  sq_wd;

   logic [35:0]    mul_a;
   logic [31:0]    mul_b;
   logic [67:0]    mul_p;

   logic           accept;
   logic [EW-1:0]  w_eff, h_eff;
   logic [8:0]     ws_lo;
   logic [9:0]     ws;
   logic [7:0]     half;
   logic [EW-1:0]  y1c, x1c, cr, cc, nc, nr;
   logic [8:0]     dy, dx;
   logic           restart, plus;
   logic [31:0]    val_s, val_q;
   logic [64:0]    rem_sh;
   logic           ge;
   logic [63:0]    rem_nx, sq_t;
   logic [32:0]    u;
   logic [47:0]    n_c;
   logic [95:0]    lhs;
   logic [SW-1:0]  above_s;
   logic [QW-1:0]  above_q;

   assign accept = start && !busy;
   assign busy   = (state_ff != sauv_pkg::ST_IDLE);
   assign mul_p  = mul_a * mul_b;

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_is_white        = rsp_white_ff;
   assign rsp_local_mean      = rsp_mean_ff;
   assign rsp_local_deviation = rsp_dev_ff;

   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = EW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(width_ff);
      end
      if (height_ff == 9'd0) begin
         h_eff = EW'(1);
      end else if (EW'(height_ff) > EW'(MAX_HEIGHT)) begin
         h_eff = EW'(MAX_HEIGHT);
      end else begin
         h_eff = EW'(height_ff);
      end
      ws_lo = (window_ff < 9'd3) ? 9'd3 : window_ff;
      ws    = ws_lo[0] ? {1'b0, ws_lo} : ({1'b0, ws_lo} + 10'd1);
      half  = ws[8:1];
   end

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      window_in     = window_ff;
      k_in          = k_ff;
      delta_in      = delta_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rs_in         = rs_ff;
      rq_in         = rq_ff;
      loaded_in     = loaded_ff;
      qrow_in       = qrow_ff;
      qcol_in       = qcol_ff;
      y0_in         = y0_ff;
      y1_in         = y1_ff;
      x0_in         = x0_ff;
      x1_in         = x1_ff;
      cnt_in        = cnt_ff;
      rd_act_in     = 1'b0;
      rd_zf_in      = rd_zf_ff;
      rd_idx_in     = rd_idx_ff;
      s_in          = s_ff;
      q_in          = q_ff;
      p_in          = p_ff;
      area_in       = area_ff;
      aq_in         = aq_ff;
      ss_in         = ss_ff;
      vnum_in       = vnum_ff;
      a2_in         = a2_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      mq_in         = mq_ff;
      mpl_in        = mpl_ff;
      quo1_in       = quo1_ff;
      dq_in         = dq_ff;
      ku_in         = ku_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_white_in  = rsp_white_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_dev_in    = rsp_dev_ff;
      mem_we        = 1'b0;
      wr_addr       = AW'(row_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
      rd_addr       = wr_addr - AW'(MAX_WIDTH);
      sum_wd        = '0;
      sq_wd         = '0;
      mul_a         = '0;
      mul_b         = '0;
      cr            = '0;
      cc            = '0;
      y1c           = EW'(qrow_ff) + EW'(half) + EW'(1);
      x1c           = EW'(qcol_ff) + EW'(half) + EW'(1);
      dy            = 9'(y1_ff - y0_ff);
      dx            = 9'(x1_ff - x0_ff);
      restart       = loaded_ff || (EW'(col_ff) >= w_eff) || (EW'(row_ff) >= h_eff);
      nc            = EW'(col_ff) + EW'(1);
      nr            = EW'(row_ff) + EW'(1);
      above_s       = (row_ff != '0) ? rd_sum_ff : '0;
      above_q       = (row_ff != '0) ? rd_sq_ff : '0;
      rem_sh        = {rem_ff, dvd_ff[63]};
      ge            = (rem_sh >= {1'b0, dvs_ff});
      rem_nx        = ge ? 64'(rem_sh - {1'b0, dvs_ff}) : rem_sh[63:0];
      sq_t          = quo_ff + dvs_ff;
      u             = 33'(quo_ff[31:0]) + 33'({delta_ff ^ 8'h80, 16'h0000});
      n_c           = 48'h0000_8000_0000 - 48'({k_ff, 24'h000000}) + 48'(ku_ff);
      lhs           = {41'd0, p_ff, 47'd0};

      // table reads land in the cycle after issue
      val_s = rd_zf_ff ? 32'd0 : 32'(rd_sum_ff);
      val_q = rd_zf_ff ? 32'd0 : rd_sq_ff;
      plus  = (rd_idx_ff[1:0] == 2'd0) || (rd_idx_ff[1:0] == 2'd3);
      if (rd_act_ff) begin
         if (!rd_idx_ff[2]) begin
            s_in = plus ? (s_ff + val_s) : (s_ff - val_s);
            q_in = plus ? (q_ff + val_q) : (q_ff - val_q);
         end else begin
            p_in = plus ? (p_ff + val_s[7:0]) : (p_ff - val_s[7:0]);
         end
      end

      unique case (state_ff)
         sauv_pkg::ST_IDLE: begin
            mul_a = 36'(req_pixel);
            mul_b = 32'(req_pixel);
            if (accept) begin
               if (req_func == sauv_pkg::FUNC_LOAD) begin
                  rs_in = (restart ? RSW'(0) : rs_ff) + RSW'(req_pixel);
                  rq_in = (restart ? RQW'(0) : rq_ff) + RQW'(mul_p[15:0]);
                  if (restart) begin
                     col_in    = '0;
                     row_in    = '0;
                     loaded_in = 1'b0;
                  end
                  state_in = sauv_pkg::ST_LD_RD;
               end else begin
                  qrow_in = req_row;
                  qcol_in = req_col;
                  if (!loaded_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = sauv_pkg::STATUS_NOT_LOADED;
                     rsp_white_in  = 1'b0;
                     rsp_mean_in   = '0;
                     rsp_dev_in    = '0;
                  end else if ((EW'(req_col) >= w_eff) || (EW'(req_row) >= h_eff)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = sauv_pkg::STATUS_RANGE;
                     rsp_white_in  = 1'b0;
                     rsp_mean_in   = '0;
                     rsp_dev_in    = '0;
                  end else begin
                     state_in = sauv_pkg::ST_Q_BND;
                  end
               end
            end
         end
         sauv_pkg::ST_LD_RD: begin
            state_in = sauv_pkg::ST_LD_WR;
         end
         sauv_pkg::ST_LD_WR: begin
            mem_we = 1'b1;
            sum_wd = above_s + SW'(rs_ff);
            sq_wd  = above_q + QW'(rq_ff);
            if (nc >= w_eff) begin
               col_in = '0;
               rs_in  = '0;
               rq_in  = '0;
               if (nr >= h_eff) begin
                  row_in    = '0;
                  loaded_in = 1'b1;
               end else begin
                  row_in = RW'(nr);
               end
            end else begin
               col_in = CW'(nc);
            end
            state_in = sauv_pkg::ST_IDLE;
         end
         sauv_pkg::ST_Q_BND: begin
            y0_in    = (qrow_ff > half) ? EW'(qrow_ff - half) : '0;
            x0_in    = (qcol_ff > half) ? EW'(qcol_ff - half) : '0;
            y1_in    = (y1c < h_eff) ? y1c : h_eff;
            x1_in    = (x1c < w_eff) ? x1c : w_eff;
            s_in     = '0;
            q_in     = '0;
            p_in     = '0;
            cnt_in   = '0;
            state_in = sauv_pkg::ST_Q_RD;
         end
         sauv_pkg::ST_Q_RD: begin
            case (cnt_ff[2:0])
               3'd0:    begin cr = y1_ff; cc = x1_ff; end
               3'd1:    begin cr = y0_ff; cc = x1_ff; end
               3'd2:    begin cr = y1_ff; cc = x0_ff; end
               3'd3:    begin cr = y0_ff; cc = x0_ff; end
               3'd4:    begin cr = EW'(qrow_ff) + EW'(1); cc = EW'(qcol_ff) + EW'(1); end
               3'd5:    begin cr = EW'(qrow_ff); cc = EW'(qcol_ff) + EW'(1); end
               3'd6:    begin cr = EW'(qrow_ff) + EW'(1); cc = EW'(qcol_ff); end
               default: begin cr = EW'(qrow_ff); cc = EW'(qcol_ff); end
            endcase
            rd_addr   = AW'(cr - EW'(1)) * AW'(MAX_WIDTH) + AW'(cc - EW'(1));
            rd_zf_in  = (cr == '0) || (cc == '0);
            rd_idx_in = cnt_ff[2:0];
            rd_act_in = (cnt_ff < 7'd8);
            cnt_in    = cnt_ff + 7'd1;
            if (cnt_ff == 7'd8) begin
               state_in = sauv_pkg::ST_Q_AREA;
            end
         end
         sauv_pkg::ST_Q_AREA: begin
            mul_a    = 36'(dy);
            mul_b    = 32'(dx);
            area_in  = 18'(mul_p);
            state_in = sauv_pkg::ST_Q_AQ;
         end
         sauv_pkg::ST_Q_AQ: begin
            mul_a    = 36'(area_ff);
            mul_b    = q_ff;
            aq_in    = mul_p[63:0];
            state_in = sauv_pkg::ST_Q_SS;
         end
         sauv_pkg::ST_Q_SS: begin
            mul_a    = 36'(s_ff);
            mul_b    = s_ff;
            ss_in    = mul_p[63:0];
            state_in = sauv_pkg::ST_Q_VN;
         end
         sauv_pkg::ST_Q_VN: begin
            vnum_in  = (aq_ff > ss_ff) ? (aq_ff - ss_ff) : 64'd0;
            mul_a    = 36'(area_ff);
            mul_b    = 32'(area_ff);
            a2_in    = 36'(mul_p);
            dvd_in   = {16'h0000, s_ff, 16'h0000};
            dvs_in   = 64'(area_ff);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = sauv_pkg::ST_Q_D1;
         end
         sauv_pkg::ST_Q_D1, sauv_pkg::ST_Q_D2, sauv_pkg::ST_Q_D3: begin
            rem_in = rem_nx;
            quo_in = {quo_ff[62:0], ge};
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               if (state_ff == sauv_pkg::ST_Q_D1) begin
                  state_in = sauv_pkg::ST_Q_D2S;
               end else if (state_ff == sauv_pkg::ST_Q_D2) begin
                  state_in = sauv_pkg::ST_Q_D3S;
               end else begin
                  state_in = sauv_pkg::ST_Q_SQS;
               end
            end
         end
         sauv_pkg::ST_Q_D2S: begin
            mq_in    = quo_ff[47:0];
            dvd_in   = vnum_ff;
            dvs_in   = 64'(a2_ff);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = sauv_pkg::ST_Q_D2;
         end
         sauv_pkg::ST_Q_D3S: begin
            quo1_in  = quo_ff[31:0];
            dvd_in   = {rem_ff[31:0], 32'h0000_0000};
            dvs_in   = 64'(a2_ff);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = sauv_pkg::ST_Q_D3;
         end
         sauv_pkg::ST_Q_SQS: begin
            rem_in   = {quo1_ff, 32'h0000_0000} + quo_ff;
            quo_in   = '0;
            dvs_in   = 64'h4000_0000_0000_0000;
            cnt_in   = '0;
            state_in = sauv_pkg::ST_Q_SQ;
         end
         sauv_pkg::ST_Q_SQ: begin
            if (rem_ff >= sq_t) begin
               rem_in = rem_ff - sq_t;
               quo_in = (quo_ff >> 1) + dvs_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            dvs_in = dvs_ff >> 2;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               state_in = sauv_pkg::ST_Q_KU;
            end
         end
         sauv_pkg::ST_Q_KU: begin
            mul_a    = 36'(u);
            mul_b    = 32'(k_ff);
            ku_in    = 43'(mul_p);
            dq_in    = quo_ff[31:0];
            state_in = sauv_pkg::ST_Q_N;
         end
         sauv_pkg::ST_Q_N: begin
            acc_in   = '0;
            mcand_in = {{48{n_c[47]}}, n_c};
            mpl_in   = mq_ff;
            state_in = sauv_pkg::ST_Q_MUL;
         end
         sauv_pkg::ST_Q_MUL: begin
            if (mpl_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = sauv_pkg::STATUS_OK;
               rsp_white_in  = !($signed(lhs) < $signed(acc_ff));
               rsp_mean_in   = mq_ff[23:8];
               rsp_dev_in    = dq_ff[22:8];
               state_in      = sauv_pkg::ST_IDLE;
            end else begin
               if (mpl_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in = {mcand_ff[94:0], 1'b0};
               mpl_in   = mpl_ff >> 1;
            end
         end
         default: begin
            state_in = sauv_pkg::ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            sauv_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[8:0];
            sauv_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata[8:0];
            sauv_pkg::CSR_WINDOW_SIZE:  window_in = csr_wdata[8:0];
            sauv_pkg::CSR_K_GAIN:       k_in      = csr_wdata;
            sauv_pkg::CSR_DELTA_OFFSET: delta_in  = csr_wdata[7:0];
            default: ;
         endcase
         if ((csr_index == sauv_pkg::CSR_IMAGE_WIDTH) ||
             (csr_index == sauv_pkg::CSR_IMAGE_HEIGHT)) begin
            col_in    = '0;
            row_in    = '0;
            rs_in     = '0;
            rq_in     = '0;
            loaded_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sauv_pkg::ST_IDLE;
         width_ff      <= 9'd256;
         height_ff     <= 9'd256;
         window_ff     <= 9'd15;
         k_ff          <= 10'd51;
         delta_ff      <= 8'd0;
         col_ff        <= '0;
         row_ff        <= '0;
         rs_ff         <= '0;
         rq_ff         <= '0;
         loaded_ff     <= 1'b0;
         rd_act_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         window_ff     <= window_in;
         k_ff          <= k_in;
         delta_ff      <= delta_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rs_ff         <= rs_in;
         rq_ff         <= rq_in;
         loaded_ff     <= loaded_in;
         rd_act_ff     <= rd_act_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      qrow_ff       <= qrow_in;
      qcol_ff       <= qcol_in;
      y0_ff         <= y0_in;
      y1_ff         <= y1_in;
      x0_ff         <= x0_in;
      x1_ff         <= x1_in;
      cnt_ff        <= cnt_in;
      rd_zf_ff      <= rd_zf_in;
      rd_idx_ff     <= rd_idx_in;
      s_ff          <= s_in;
      q_ff          <= q_in;
      p_ff          <= p_in;
      area_ff       <= area_in;
      aq_ff         <= aq_in;
      ss_ff         <= ss_in;
      vnum_ff       <= vnum_in;
      a2_ff         <= a2_in;
      dvd_ff        <= dvd_in;
      dvs_ff        <= dvs_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      mq_ff         <= mq_in;
      mpl_ff        <= mpl_in;
      quo1_ff       <= quo1_in;
      dq_ff         <= dq_in;
      ku_ff         <= ku_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      rsp_status_ff <= rsp_status_in;
      rsp_white_ff  <= rsp_white_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_dev_ff    <= rsp_dev_in;
   end

   // integral tables
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[wr_addr] <= sum_wd;
         sq_mem[wr_addr]  <= sq_wd;
      end
      rd_sum_ff <= sum_mem[rd_addr];
      rd_sq_ff  <= sq_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != sauv_pkg::STATUS_OK)) |->
      (!rsp_is_white && (rsp_local_mean == 16'd0) && (rsp_local_deviation == 15'd0)))
      else $error("error word carries non-zero fields");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == sauv_pkg::FUNC_LOAD)) |=> busy)
      else $error("load word did not occupy the block");

   a_not_loaded: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == sauv_pkg::FUNC_QUERY) && !loaded_ff) |=>
      (rsp_strobe && (rsp_status == sauv_pkg::STATUS_NOT_LOADED)))
      else $error("query before load complete not refused");

   a_ok_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == sauv_pkg::STATUS_OK)) |->
      ($past(state_ff) == sauv_pkg::ST_Q_MUL))
      else $error("ok word without finished computation");
`endif

endmodule

`default_nettype wire
